// ===== hw/rtl/rm2ypr_pkg.sv =====
// ============================================================================
// rm2ypr_pkg
// Shared types and constants for the rotation matrix to yaw/pitch/roll block.
// ============================================================================
package rm2ypr_pkg;

    // Entry width of the Q1.14 matrix and of the output angles.
    localparam int IN_W = 16;
    localparam int OUT_W = 16;

    // Internal angles are kept in units of 2^-20 degree.
    localparam int INT_FRAC = 20;
    localparam int ZW = 30;

    // Width of one atan2 operand (a negated entry or a negated root).
    localparam int OPW = 18;

    // Width of the Q1.14 sine and cosine values.
    localparam int SCW = 17;

    // Configuration register widths and reset values.
    localparam int TOL_W = 14;
    localparam int RATIO_W = 9;
    localparam int CFG_W = 14;
    localparam logic [TOL_W-1:0] TOL_RESET = 14'd16;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd243;

    // Register indexes on the configuration port.
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_SELECT_RATIO = 1'b1;

    // Angle constants in 2^-20 degree.
    localparam logic signed [ZW-1:0] DEG90 = 30'sd94371840;
    localparam logic signed [ZW-1:0] DEG180 = 30'sd188743680;

    // Start value of the rotation CORDIC, the inverse gain in Q2.30.
    localparam int SCX_W = 33;
    localparam logic signed [SCX_W-1:0] KGAIN = 33'sd652032874;

    // atan(2^-i) in 2^-20 degree, rounded to nearest.
    localparam int ATAN_N = 24;
    localparam logic signed [ZW-1:0] ATAN_TAB [ATAN_N] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    // Nine matrix entries, row major, entry 0 in the low bits.
    typedef logic [8:0][IN_W-1:0] mvec_t;

    // One input beat: a full rotation matrix.
    typedef struct packed {
        logic signed [IN_W-1:0] entry_r0c0;
        logic signed [IN_W-1:0] entry_r0c1;
        logic signed [IN_W-1:0] entry_r0c2;
        logic signed [IN_W-1:0] entry_r1c0;
        logic signed [IN_W-1:0] entry_r1c1;
        logic signed [IN_W-1:0] entry_r1c2;
        logic signed [IN_W-1:0] entry_r2c0;
        logic signed [IN_W-1:0] entry_r2c1;
        logic signed [IN_W-1:0] entry_r2c2;
    } matrix_t;

    // One output beat: the three angles and two flags.
    typedef struct packed {
        logic signed [OUT_W-1:0] yaw_angle;
        logic signed [OUT_W-1:0] pitch_angle;
        logic signed [OUT_W-1:0] roll_angle;
        logic match_ok;
        logic gimbal_locked;
    } angles_t;

    // Sign-extends a matrix entry to atan2 operand width.
    function automatic logic signed [OPW-1:0] to_operand(input logic [IN_W-1:0] v);
        return OPW'($signed(v));
    endfunction

endpackage

// ===== hw/rtl/rotation_matrix_to_ypr_angles_top.sv =====
// ============================================================================
// rotation_matrix_to_ypr_angles_top
// Converts a Q1.14 rotation matrix into yaw, pitch and roll angles.
// ============================================================================
// The block takes one matrix beat in every clock cycle while matrix_ready is
// high and returns one angle beat per matrix, in order. Each beat passes
// through the front-end registers, a 16-stage square root, the vectoring
// CORDIC, the three-stage solution selection, the rotation CORDIC, the
// four-stage matrix rebuild and the output register. The whole
// pipeline advances as one; when an output beat waits for its consumer, the
// pipeline holds and matrix_ready drops until the beat is taken. Tolerance and
// select ratio should be written only while no beat is in flight.
module rotation_matrix_to_ypr_angles_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              matrix_valid,
    output logic                              matrix_ready,
    input  rm2ypr_pkg::matrix_t               matrix_data,
    output logic                              angles_valid,
    input  logic                              angles_ready,
    output rm2ypr_pkg::angles_t               angles_data,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rm2ypr_pkg::CFG_W-1:0]      cfg_data
);

    localparam int ANG_W = ANGLE_FRAC_BITS + 9;
    localparam int OPW = rm2ypr_pkg::OPW;
    localparam int SCW = rm2ypr_pkg::SCW;
    localparam int SQ_LAT = 16;
    localparam int AT_LAT = CORDIC_STAGES + 2;
    localparam int SEL_LAT = 3;
    localparam int SC_LAT = CORDIC_STAGES + 2;
    localparam int RB_LAT = 4;
    localparam int M_DL = SQ_LAT + AT_LAT + SEL_LAT + SC_LAT;
    localparam int A_DL = SC_LAT + RB_LAT;
    localparam int TOT = 3 + SQ_LAT + AT_LAT + SEL_LAT + SC_LAT + RB_LAT + 1;

    typedef struct packed {
        logic                    gimbal;
        logic signed [ANG_W-1:0] yaw;
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] roll;
    } ang_pack_t;

    // Configuration registers.
    logic [rm2ypr_pkg::TOL_W-1:0]   tol_reg;
    logic [rm2ypr_pkg::RATIO_W-1:0] ratio_reg;

    // Pipeline control.
    logic           en;
    logic [TOT-1:0] vld_reg;

    // Front end: input, squares, sum.
    rm2ypr_pkg::mvec_t m_in;
    rm2ypr_pkg::mvec_t m1_reg;
    rm2ypr_pkg::mvec_t m2_reg;
    rm2ypr_pkg::mvec_t m3_reg;
    logic [30:0]       sq7_reg;
    logic [30:0]       sq8_reg;
    logic [31:0]       sum_reg;
    logic signed [31:0] sq7_full;
    logic signed [31:0] sq8_full;

    // Matrix carried alongside the datapath.
    rm2ypr_pkg::mvec_t m_dl_reg [M_DL];
    rm2ypr_pkg::mvec_t m_sq;
    rm2ypr_pkg::mvec_t m_rb;

    logic [15:0]          root;
    logic                 gimbal_now;
    logic                 g_dl_reg [AT_LAT];
    logic signed [OPW-1:0] op_y [6];
    logic signed [OPW-1:0] op_x [6];
    logic signed [OPW-1:0] root_op;
    logic signed [ANG_W-1:0] at_ang [6];
    logic signed [ANG_W-1:0] cand_a [3];
    logic signed [ANG_W-1:0] cand_b [3];
    logic signed [ANG_W-1:0] ang_sel [3];
    logic                 gimbal_sel;
    logic signed [SCW-1:0] cos_val [3];
    logic signed [SCW-1:0] sin_val [3];
    logic                 rb_ok;
    ang_pack_t            a_dl_reg [A_DL];
    ang_pack_t            ang_end;
    rm2ypr_pkg::angles_t  out_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= rm2ypr_pkg::TOL_RESET;
            ratio_reg <= rm2ypr_pkg::RATIO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rm2ypr_pkg::REG_TOLERANCE:    tol_reg <= cfg_data[rm2ypr_pkg::TOL_W-1:0];
                rm2ypr_pkg::REG_SELECT_RATIO: ratio_reg <= cfg_data[rm2ypr_pkg::RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves unless the output beat is held by the consumer.
    assign en = !vld_reg[TOT-1] || angles_ready;
    assign matrix_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOT-2:0], matrix_valid};
        end
    end

    // Front end: register the matrix, square the last row's tail, add.
    assign m_in = {matrix_data.entry_r2c2, matrix_data.entry_r2c1, matrix_data.entry_r2c0,
                   matrix_data.entry_r1c2, matrix_data.entry_r1c1, matrix_data.entry_r1c0,
                   matrix_data.entry_r0c2, matrix_data.entry_r0c1, matrix_data.entry_r0c0};
    assign sq7_full = $signed(m1_reg[7]) * $signed(m1_reg[7]);
    assign sq8_full = $signed(m1_reg[8]) * $signed(m1_reg[8]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m_in;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
            sq7_reg <= sq7_full[30:0];
            sq8_reg <= sq8_full[30:0];
            sum_reg <= 32'(sq7_reg) + 32'(sq8_reg);
            m_dl_reg[0] <= m3_reg;
            for (int k = 1; k < M_DL; k++)
            begin
                m_dl_reg[k] <= m_dl_reg[k-1];
            end
            g_dl_reg[0] <= gimbal_now;
            for (int k = 1; k < AT_LAT; k++)
            begin
                g_dl_reg[k] <= g_dl_reg[k-1];
            end
            a_dl_reg[0] <= '{gimbal_sel, ang_sel[0], ang_sel[1], ang_sel[2]};
            for (int k = 1; k < A_DL; k++)
            begin
                a_dl_reg[k] <= a_dl_reg[k-1];
            end
            out_reg.yaw_angle <= 16'(ang_end.yaw);
            out_reg.pitch_angle <= 16'(ang_end.pitch);
            out_reg.roll_angle <= 16'(ang_end.roll);
            out_reg.match_ok <= rb_ok;
            out_reg.gimbal_locked <= ang_end.gimbal;
        end
    end

    assign m_sq = m_dl_reg[SQ_LAT-1];
    assign m_rb = m_dl_reg[M_DL-1];
    assign ang_end = a_dl_reg[A_DL-1];

    // Length of the last row's last two entries.
    rm2ypr_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    // Gimbal test and atan2 operands for both solutions.
    assign gimbal_now = 17'(root) < 17'(tol_reg);
    assign root_op = OPW'(root);

    always_comb
    begin
        if (gimbal_now)
        begin
            op_y[0] = -rm2ypr_pkg::to_operand(m_sq[1]);
            op_x[0] = rm2ypr_pkg::to_operand(m_sq[4]);
        end
        else
        begin
            op_y[0] = rm2ypr_pkg::to_operand(m_sq[3]);
            op_x[0] = rm2ypr_pkg::to_operand(m_sq[0]);
        end
        op_y[1] = rm2ypr_pkg::to_operand(m_sq[6]);
        op_x[1] = root_op;
        op_y[2] = rm2ypr_pkg::to_operand(m_sq[7]);
        op_x[2] = rm2ypr_pkg::to_operand(m_sq[8]);
        op_y[3] = -rm2ypr_pkg::to_operand(m_sq[3]);
        op_x[3] = -rm2ypr_pkg::to_operand(m_sq[0]);
        op_y[4] = rm2ypr_pkg::to_operand(m_sq[6]);
        op_x[4] = -root_op;
        op_y[5] = -rm2ypr_pkg::to_operand(m_sq[7]);
        op_x[5] = -rm2ypr_pkg::to_operand(m_sq[8]);
    end

    // Six vectoring CORDIC pipelines.
    for (genvar g = 0; g < 6; g++)
    begin : g_atan
        rm2ypr_atan2 #(
            .NSTG (CORDIC_STAGES),
            .FRAC (ANGLE_FRAC_BITS)
        ) u_atan2 (
            .clk   (clk),
            .en    (en),
            .y     (op_y[g]),
            .x     (op_x[g]),
            .angle (at_ang[g])
        );
    end

    assign cand_a = '{at_ang[0], at_ang[1], at_ang[2]};
    assign cand_b = '{at_ang[3], at_ang[4], at_ang[5]};

    // Choice between the two solutions.
    rm2ypr_select #(
        .FRAC (ANGLE_FRAC_BITS)
    ) u_select (
        .clk        (clk),
        .en         (en),
        .ratio      (ratio_reg),
        .gimbal     (g_dl_reg[AT_LAT-1]),
        .cand_a     (cand_a),
        .cand_b     (cand_b),
        .angle      (ang_sel),
        .gimbal_out (gimbal_sel)
    );

    // Sine and cosine of the three chosen angles.
    for (genvar g = 0; g < 3; g++)
    begin : g_sincos
        rm2ypr_sincos #(
            .NSTG (CORDIC_STAGES),
            .FRAC (ANGLE_FRAC_BITS)
        ) u_sincos (
            .clk     (clk),
            .en      (en),
            .angle   (ang_sel[g]),
            .cos_val (cos_val[g]),
            .sin_val (sin_val[g])
        );
    end

    // Rebuild and tolerance check.
    rm2ypr_rebuild u_rebuild (
        .clk     (clk),
        .en      (en),
        .tol     (tol_reg),
        .mat     (m_rb),
        .cos_val (cos_val),
        .sin_val (sin_val),
        .ok      (rb_ok)
    );

    assign angles_valid = vld_reg[TOT-1];
    assign angles_data = out_reg;

`ifndef SYNTHESIS
    // The gimbal-lock form always reports zero roll.
    a_gimbal_roll: assert property (@(posedge clk) disable iff (!rst_n)
        angles_valid && angles_data.gimbal_locked |-> angles_data.roll_angle == '0)
        else $error("gimbal-locked beat with nonzero roll");

    // With zero tolerance no rebuilt matrix can match.
    a_zero_tol: assert property (@(posedge clk) disable iff (!rst_n)
        angles_valid && tol_reg == '0 |-> !angles_data.match_ok)
        else $error("match reported with zero tolerance");
`endif

endmodule

// ===== hw/rtl/rm2ypr_isqrt.sv =====
// ============================================================================
// rm2ypr_isqrt
// Pipelined integer square root, one result bit per register stage.
// ============================================================================
module rm2ypr_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] radicand,
    output logic [15:0] root
);

    localparam int STEPS = 16;

    logic [31:0] rem_reg [STEPS];
    logic [31:0] res_reg [STEPS];

    // One digit of the classic bitwise square root.
    function automatic logic [63:0] sqrt_step(
        input logic [31:0] rem,
        input logic [31:0] res,
        input int          k
    );
        logic [31:0] bitv;
        logic [31:0] trial;
        bitv = 32'(1) << (30 - 2 * k);
        trial = res + bitv;
        if (rem >= trial)
        begin
            return {rem - trial, (res >> 1) + bitv};
        end
        return {rem, res >> 1};
    endfunction

    // Each stage settles one bit of the root.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            {rem_reg[0], res_reg[0]} <= sqrt_step(radicand, '0, 0);
            for (int k = 1; k < STEPS; k++)
            begin
                {rem_reg[k], res_reg[k]} <= sqrt_step(rem_reg[k-1], res_reg[k-1], k);
            end
        end
    end

    assign root = res_reg[STEPS-1][15:0];

endmodule

// ===== hw/rtl/rm2ypr_atan2.sv =====
// ============================================================================
// rm2ypr_atan2
// Pipelined vectoring CORDIC giving atan2(y, x) rounded to output units.
// ============================================================================
module rm2ypr_atan2 #(
    parameter int NSTG = 16,
    parameter int FRAC = 7
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [rm2ypr_pkg::OPW-1:0]    y,
    input  logic signed [rm2ypr_pkg::OPW-1:0]    x,
    output logic signed [FRAC+8:0]               angle
);

    localparam int ANG_W = FRAC + 9;
    localparam int XW = 36;
    localparam int ZW = rm2ypr_pkg::ZW;
    localparam int OUT_SHIFT = rm2ypr_pkg::INT_FRAC - FRAC;
    localparam logic signed [ZW-1:0] RND_HALF = ZW'(1 << (OUT_SHIFT - 1));

    logic signed [XW-1:0] x_reg [NSTG+1];
    logic signed [XW-1:0] y_reg [NSTG+1];
    logic signed [ZW-1:0] z_reg [NSTG+1];
    logic                 zero_reg [NSTG+1];
    logic signed [ANG_W-1:0] angle_reg;

    logic signed [rm2ypr_pkg::OPW-1:0] x_pre;
    logic signed [rm2ypr_pkg::OPW-1:0] y_pre;
    logic signed [ZW-1:0] z_pre;
    logic signed [ZW-1:0] z_cl;
    logic signed [ZW-1:0] z_rnd;

    // Move a left half-plane vector to the right half plane by 180 degrees.
    always_comb
    begin
        x_pre = x;
        y_pre = y;
        z_pre = '0;
        if (x[rm2ypr_pkg::OPW-1])
        begin
            z_pre = y[rm2ypr_pkg::OPW-1] ? -rm2ypr_pkg::DEG180 : rm2ypr_pkg::DEG180;
            x_pre = -x;
            y_pre = -y;
        end
    end

    // Entry stage and the micro-rotation stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= XW'(x_pre) <<< 16;
            y_reg[0] <= XW'(y_pre) <<< 16;
            z_reg[0] <= z_pre;
            zero_reg[0] <= (x == '0) && (y == '0);
            for (int i = 0; i < NSTG; i++)
            begin
                if (!y_reg[i][XW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + rm2ypr_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - rm2ypr_pkg::ATAN_TAB[i];
                end
                zero_reg[i+1] <= zero_reg[i];
            end
            angle_reg <= z_rnd[ANG_W-1:0];
        end
    end

    // Clamp to a half turn, then round half up to output units.
    always_comb
    begin
        z_cl = z_reg[NSTG];
        if (z_cl > rm2ypr_pkg::DEG180)
        begin
            z_cl = rm2ypr_pkg::DEG180;
        end
        else if (z_cl < -rm2ypr_pkg::DEG180)
        begin
            z_cl = -rm2ypr_pkg::DEG180;
        end
        if (zero_reg[NSTG])
        begin
            z_cl = '0;
        end
        z_rnd = (z_cl + RND_HALF) >>> OUT_SHIFT;
    end

    assign angle = angle_reg;

endmodule

// ===== hw/rtl/rm2ypr_select.sv =====
// ============================================================================
// rm2ypr_select
// Picks one of the two angle solutions, or the gimbal-lock form.
// ============================================================================
module rm2ypr_select #(
    parameter int FRAC = 7
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [rm2ypr_pkg::RATIO_W-1:0]         ratio,
    input  logic                                   gimbal,
    input  logic signed [FRAC+8:0]                 cand_a [3],
    input  logic signed [FRAC+8:0]                 cand_b [3],
    output logic signed [FRAC+8:0]                 angle [3],
    output logic                                   gimbal_out
);

    localparam int ANG_W = FRAC + 9;
    localparam int MW = ANG_W - 1;
    localparam int PW = MW + rm2ypr_pkg::RATIO_W;
    localparam int SQW = 2 * MW;
    localparam int SSW = SQW + 2;

    logic [MW-1:0] abs_a [3];
    logic [MW-1:0] abs_b [3];
    logic [MW-1:0] max_a;
    logic [MW-1:0] max_b;

    logic signed [ANG_W-1:0] a1_reg [3];
    logic signed [ANG_W-1:0] b1_reg [3];
    logic                    g1_reg;
    logic [MW-1:0]           ma1_reg;
    logic [MW-1:0]           mb1_reg;
    logic [SQW-1:0]          sqa_reg [3];
    logic [SQW-1:0]          sqb_reg [3];

    logic signed [ANG_W-1:0] a2_reg [3];
    logic signed [ANG_W-1:0] b2_reg [3];
    logic                    g2_reg;
    logic [PW-1:0]           sa_reg;
    logic [PW-1:0]           sb_reg;
    logic [PW-1:0]           ra_reg;
    logic [PW-1:0]           rb_reg;
    logic [SSW-1:0]          ssa_reg;
    logic [SSW-1:0]          ssb_reg;

    logic signed [ANG_W-1:0] pick [3];
    logic signed [ANG_W-1:0] angle_reg [3];
    logic                    g3_reg;

    // Magnitudes and their maximum per candidate.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            abs_a[k] = cand_a[k][ANG_W-1] ? MW'(-cand_a[k]) : MW'(cand_a[k]);
            abs_b[k] = cand_b[k][ANG_W-1] ? MW'(-cand_b[k]) : MW'(cand_b[k]);
        end
        max_a = abs_a[0];
        if (abs_a[1] > max_a)
        begin
            max_a = abs_a[1];
        end
        if (abs_a[2] > max_a)
        begin
            max_a = abs_a[2];
        end
        max_b = abs_b[0];
        if (abs_b[1] > max_b)
        begin
            max_b = abs_b[1];
        end
        if (abs_b[2] > max_b)
        begin
            max_b = abs_b[2];
        end
    end

    // Stage one squares, stage two ratio products and sums of squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a1_reg[k] <= cand_a[k];
                b1_reg[k] <= cand_b[k];
                sqa_reg[k] <= SQW'(abs_a[k]) * SQW'(abs_a[k]);
                sqb_reg[k] <= SQW'(abs_b[k]) * SQW'(abs_b[k]);
                a2_reg[k] <= a1_reg[k];
                b2_reg[k] <= b1_reg[k];
                angle_reg[k] <= pick[k];
            end
            g1_reg <= gimbal;
            ma1_reg <= max_a;
            mb1_reg <= max_b;

            g2_reg <= g1_reg;
            sa_reg <= PW'({ma1_reg, 8'b0});
            sb_reg <= PW'({mb1_reg, 8'b0});
            ra_reg <= PW'(ratio) * PW'(mb1_reg);
            rb_reg <= PW'(ratio) * PW'(ma1_reg);
            ssa_reg <= SSW'(sqa_reg[0]) + SSW'(sqa_reg[1]) + SSW'(sqa_reg[2]);
            ssb_reg <= SSW'(sqb_reg[0]) + SSW'(sqb_reg[1]) + SSW'(sqb_reg[2]);

            g3_reg <= g2_reg;
        end
    end

    // Solution A is tested first; ties on the sum of squares go to A.
    always_comb
    begin
        if (g2_reg)
        begin
            pick[0] = a2_reg[0];
            pick[1] = a2_reg[1];
            pick[2] = '0;
        end
        else if (sa_reg < ra_reg)
        begin
            pick = a2_reg;
        end
        else if (sb_reg < rb_reg)
        begin
            pick = b2_reg;
        end
        else if (ssa_reg <= ssb_reg)
        begin
            pick = a2_reg;
        end
        else
        begin
            pick = b2_reg;
        end
    end

    assign angle = angle_reg;
    assign gimbal_out = g3_reg;

endmodule

// ===== hw/rtl/rm2ypr_sincos.sv =====
// ============================================================================
// rm2ypr_sincos
// Pipelined rotation CORDIC giving Q1.14 cosine and sine of an output angle.
// ============================================================================
module rm2ypr_sincos #(
    parameter int NSTG = 16,
    parameter int FRAC = 7
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [FRAC+8:0]               angle,
    output logic signed [rm2ypr_pkg::SCW-1:0]    cos_val,
    output logic signed [rm2ypr_pkg::SCW-1:0]    sin_val
);

    localparam int ZW = rm2ypr_pkg::ZW;
    localparam int XW = rm2ypr_pkg::SCX_W;
    localparam int SCW = rm2ypr_pkg::SCW;
    localparam int OUT_SHIFT = rm2ypr_pkg::INT_FRAC - FRAC;
    localparam logic signed [XW-1:0] RND_Q14 = XW'(32768);

    logic signed [XW-1:0] x_reg [NSTG+1];
    logic signed [XW-1:0] y_reg [NSTG+1];
    logic signed [ZW-1:0] z_reg [NSTG+1];
    logic                 flip_reg [NSTG+1];
    logic signed [SCW-1:0] cos_reg;
    logic signed [SCW-1:0] sin_reg;

    logic signed [ZW-1:0] z_wide;
    logic signed [ZW-1:0] z_fold;
    logic                 flip;
    logic signed [XW-1:0] x_rnd;
    logic signed [XW-1:0] y_rnd;
    logic signed [SCW-1:0] c_fin;
    logic signed [SCW-1:0] s_fin;

    // Widen to 2^-20 degree and fold into the right half plane.
    always_comb
    begin
        z_wide = ZW'(angle) <<< OUT_SHIFT;
        z_fold = z_wide;
        flip = 1'b0;
        if (z_wide > rm2ypr_pkg::DEG90)
        begin
            z_fold = z_wide - rm2ypr_pkg::DEG180;
            flip = 1'b1;
        end
        else if (z_wide < -rm2ypr_pkg::DEG90)
        begin
            z_fold = z_wide + rm2ypr_pkg::DEG180;
            flip = 1'b1;
        end
    end

    // Round to Q1.14 and undo the fold.
    always_comb
    begin
        x_rnd = (x_reg[NSTG] + RND_Q14) >>> 16;
        y_rnd = (y_reg[NSTG] + RND_Q14) >>> 16;
        c_fin = x_rnd[SCW-1:0];
        s_fin = y_rnd[SCW-1:0];
        if (flip_reg[NSTG])
        begin
            c_fin = -c_fin;
            s_fin = -s_fin;
        end
    end

    // Entry stage, micro-rotations, output stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= rm2ypr_pkg::KGAIN;
            y_reg[0] <= '0;
            z_reg[0] <= z_fold;
            flip_reg[0] <= flip;
            for (int i = 0; i < NSTG; i++)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - rm2ypr_pkg::ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + rm2ypr_pkg::ATAN_TAB[i];
                end
                flip_reg[i+1] <= flip_reg[i];
            end
            cos_reg <= c_fin;
            sin_reg <= s_fin;
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== hw/rtl/rm2ypr_rebuild.sv =====
// ============================================================================
// rm2ypr_rebuild
// Rebuilds the matrix from sines and cosines and checks it against the input.
// ============================================================================
module rm2ypr_rebuild (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [rm2ypr_pkg::TOL_W-1:0]         tol,
    input  rm2ypr_pkg::mvec_t                    mat,
    input  logic signed [rm2ypr_pkg::SCW-1:0]    cos_val [3],
    input  logic signed [rm2ypr_pkg::SCW-1:0]    sin_val [3],
    output logic                                 ok
);

    localparam int SCW = rm2ypr_pkg::SCW;
    localparam int PPW = 2 * SCW;
    localparam int TW = 52;
    localparam int RW = 20;
    localparam int DW = RW + 1;

    // Pair products.
    logic signed [PPW-1:0] c0c1_reg, s0c2_reg, c0s1_reg, s0s2_reg, s0c1_reg;
    logic signed [PPW-1:0] c0c2_reg, s0s1_reg, c0s2_reg, c1s2_reg, c1c2_reg;
    logic signed [SCW-1:0] s1_1_reg, s2_1_reg, c2_1_reg;
    rm2ypr_pkg::mvec_t     m1_reg;

    // Terms at scale 2^42.
    logic signed [TW-1:0] t0_reg, t1a_reg, t1b_reg, t2a_reg, t2b_reg, t3_reg;
    logic signed [TW-1:0] t4a_reg, t4b_reg, t5a_reg, t5b_reg, t7_reg, t8_reg;
    logic signed [SCW-1:0] s1_2_reg;
    rm2ypr_pkg::mvec_t     m2_reg;

    // Rebuilt entries.
    logic signed [RW-1:0] r_reg [9];
    rm2ypr_pkg::mvec_t    m3_reg;

    logic [8:0]           flag_reg;
    logic signed [DW-1:0] diff [9];
    logic [DW-1:0]        mag [9];

    function automatic logic signed [RW-1:0] rnd28(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] t;
        t = (v + (TW'(1) <<< 27)) >>> 28;
        return t[RW-1:0];
    endfunction

    // Absolute difference of each entry against the input.
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            diff[k] = DW'(r_reg[k]) - DW'($signed(m3_reg[k]));
            mag[k] = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage one: pair products.
            c0c1_reg <= PPW'(cos_val[0]) * PPW'(cos_val[1]);
            s0c2_reg <= PPW'(sin_val[0]) * PPW'(cos_val[2]);
            c0s1_reg <= PPW'(cos_val[0]) * PPW'(sin_val[1]);
            s0s2_reg <= PPW'(sin_val[0]) * PPW'(sin_val[2]);
            s0c1_reg <= PPW'(sin_val[0]) * PPW'(cos_val[1]);
            c0c2_reg <= PPW'(cos_val[0]) * PPW'(cos_val[2]);
            s0s1_reg <= PPW'(sin_val[0]) * PPW'(sin_val[1]);
            c0s2_reg <= PPW'(cos_val[0]) * PPW'(sin_val[2]);
            c1s2_reg <= PPW'(cos_val[1]) * PPW'(sin_val[2]);
            c1c2_reg <= PPW'(cos_val[1]) * PPW'(cos_val[2]);
            s1_1_reg <= sin_val[1];
            s2_1_reg <= sin_val[2];
            c2_1_reg <= cos_val[2];
            m1_reg <= mat;

            // Stage two: triple products and scaled pair products.
            t0_reg  <= TW'(c0c1_reg) <<< 14;
            t1a_reg <= TW'(s0c2_reg) <<< 14;
            t1b_reg <= TW'(c0s1_reg) * TW'(s2_1_reg);
            t2a_reg <= TW'(s0s2_reg) <<< 14;
            t2b_reg <= TW'(c0s1_reg) * TW'(c2_1_reg);
            t3_reg  <= TW'(s0c1_reg) <<< 14;
            t4a_reg <= TW'(c0c2_reg) <<< 14;
            t4b_reg <= TW'(s0s1_reg) * TW'(s2_1_reg);
            t5a_reg <= TW'(c0s2_reg) <<< 14;
            t5b_reg <= TW'(s0s1_reg) * TW'(c2_1_reg);
            t7_reg  <= TW'(c1s2_reg) <<< 14;
            t8_reg  <= TW'(c1c2_reg) <<< 14;
            s1_2_reg <= s1_1_reg;
            m2_reg <= m1_reg;

            // Stage three: sums and rounding to Q1.14.
            r_reg[0] <= rnd28(t0_reg);
            r_reg[1] <= rnd28(-(t1a_reg + t1b_reg));
            r_reg[2] <= rnd28(t2a_reg - t2b_reg);
            r_reg[3] <= rnd28(t3_reg);
            r_reg[4] <= rnd28(t4a_reg - t4b_reg);
            r_reg[5] <= rnd28(-(t5a_reg + t5b_reg));
            r_reg[6] <= RW'(s1_2_reg);
            r_reg[7] <= rnd28(t7_reg);
            r_reg[8] <= rnd28(t8_reg);
            m3_reg <= m2_reg;

            // Stage four: per-entry tolerance check.
            for (int k = 0; k < 9; k++)
            begin
                flag_reg[k] <= mag[k] < DW'(tol);
            end
        end
    end

    assign ok = &flag_reg;

endmodule
